[hdl/ffra_pkg.sv]
package ffra_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int STATUS_W  = 2;

	typedef logic [ADDR_W-1:0] addr_t;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

	localparam addr_t REGION_START_RST = 32'h0010_0000;
	localparam addr_t REGION_END_RST   = 32'h0040_0000;

	// Request action codes.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MEM_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINAL,
		ST_FOLD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  live;
		addr_t slot_end;
		addr_t slot_start;
	} slot_word_t;

	typedef struct packed {
		logic  valid;
		addr_t value;
	} end_sample_t;

	typedef struct packed {
		logic  valid;
		logic  add;
		addr_t amount;
	} used_upd_t;

	typedef struct packed {
		logic  fit;
		logic  reach;
		addr_t new_end;
	} gap_res_t;

endpackage

[hdl/ffra_req_if.sv]
interface ffra_req_if;
	import ffra_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	addr_t request_size;
	addr_t block_address;

	modport source (output valid, action, request_size, block_address, input ready);
	modport sink (input valid, action, request_size, block_address, output ready);
endinterface

[hdl/ffra_rsp_if.sv]
interface ffra_rsp_if;
	import ffra_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	addr_t               granted_address;
	addr_t               bytes_in_use;
	addr_t               high_water;

	modport source (output valid, status, granted_address, bytes_in_use, high_water,
		input ready);
	modport sink (input valid, status, granted_address, bytes_in_use, high_water,
		output ready);
endinterface

[hdl/ffra_gap_unit.sv]
module ffra_gap_unit (
	input  ffra_pkg::addr_t    prev_end,
	input  ffra_pkg::addr_t    next_start,
	input  ffra_pkg::addr_t    size,
	input  ffra_pkg::addr_t    region_end,
	output ffra_pkg::gap_res_t res
);
	import ffra_pkg::*;

	logic [ADDR_W:0] sum1;

	// One adder with carry in gives prev_end + size + 1, the first byte past the block.
	// The gap fits when the next start is at or beyond it.
	assign sum1        = {1'b0, prev_end} + {1'b0, size} + (ADDR_W+1)'(1);
	assign res.fit     = {1'b0, next_start} >= sum1;
	assign res.reach   = sum1 >= {1'b0, region_end};
	assign res.new_end = sum1[ADDR_W-1:0];

endmodule

[hdl/ffra_stats.sv]
module ffra_stats (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  ffra_pkg::end_sample_t sample,
	input  ffra_pkg::used_upd_t   upd,
	input  ffra_pkg::addr_t       region_start,
	output ffra_pkg::addr_t       used_next,
	output ffra_pkg::addr_t       high_water
);
	import ffra_pkg::*;

	addr_t used_q;
	addr_t max_q;
	logic  max_valid_q;
	logic  take;

	// The byte count is kept as a running total that follows every table change.
	always_comb begin
		used_next = used_q;
		if (upd.valid) begin
			if (upd.add) begin
				used_next = used_q + upd.amount;
			end else begin
				used_next = used_q - upd.amount;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_next;
		end
	end

	assign take = sample.valid && (!max_valid_q || sample.value > max_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_valid_q <= 1'b0;
		end else if (clear) begin
			max_valid_q <= 1'b0;
		end else if (take) begin
			max_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			max_q <= sample.value;
		end
	end

	assign high_water = (max_valid_q && max_q > region_start) ?
		max_q - region_start - ADDR_W'(1) : '0;

endmodule

[hdl/first_fit_range_allocator_top.sv]
// A request is accepted in IDLE; the slot table is then walked over its single read port, one slot
// per cycle, and the result is registered at the end of the walk. Only one request is worked on at
// a time, but a new request is taken while a result waits.
// Reset: asynchronous, active low. After reset a clearing pass marks every slot empty before the
// first request is accepted; configuration writes are taken at once.
module first_fit_range_allocator_top #(
	parameter int SLOTS = ffra_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  ffra_pkg::addr_t                  cfg_wdata,
	ffra_req_if.sink                         req,
	ffra_rsp_if.source                       rsp
);
	import ffra_pkg::*;

	localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
	localparam logic [IW-1:0] FIRST_IDX = IW'(1);

	// Configuration registers.
	addr_t region_start_q;
	addr_t region_end_q;

	// Sequencer.
	state_t        state_q;
	state_t        state_d;
	logic [IW-1:0] cnt_q;
	logic          issue_q;

	// The slot table: one word per slot holding its live flag and its bounds. Slot 0 is the
	// sentinel and is never stored; its entry is written only by the clearing pass.
	slot_word_t    mem [SLOTS];
	slot_word_t    rd_s1;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	slot_word_t    mem_wd;

	// Request being worked on.
	logic                action_q;
	addr_t               size_q;
	addr_t               addr_q;
	addr_t               pe_q;
	logic                run_q;
	logic [IW-1:0]       run_idx_q;
	logic                any_empty_q;
	logic                done_q;
	logic                wr_en_q;
	logic [STATUS_W-1:0] status_q;
	addr_t               grant_q;
	addr_t               new_end_q;
	logic [IW-1:0]       sel_q;
	addr_t               free_len_q;

	// Output register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	addr_t               out_grant_q;
	addr_t               out_used_q;
	addr_t               out_hw_q;

	logic        accept;
	logic        out_free;
	logic        finish;
	logic        is_alloc;
	logic        free_hit;
	addr_t       gap_next;
	gap_res_t    gap;
	end_sample_t sample;
	used_upd_t   upd;
	addr_t       used_next;
	addr_t       high_water;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= REGION_START_RST;
			region_end_q   <= REGION_END_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REGION_START: region_start_q <= cfg_wdata;
				REG_REGION_END:   region_end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign is_alloc = (action_q == ACT_ALLOC);
	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	// A free matches the first live slot whose start equals the request address.
	assign free_hit = v_s1 && !is_alloc && !done_q && rd_s1.live &&
		rd_s1.slot_start == addr_q;

	// The shared gap unit compares against the next live start while walking the table and
	// against the region end once the walk has passed the last slot.
	assign gap_next = (state_q == ST_FINAL) ? region_end_q : rd_s1.slot_start;

	ffra_gap_unit u_gap (
		.prev_end   (pe_q),
		.next_start (gap_next),
		.size       (size_q),
		.region_end (region_end_q),
		.res        (gap)
	);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		finish    = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = sel_q;
		mem_wd    = '0;
		sample    = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				if (cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Every live slot except the one being freed counts toward the high-water mark.
				sample.valid = v_s1 && rd_s1.live && !free_hit;
				sample.value = rd_s1.slot_end;
				if (v_s1 && idx_s1 == LAST_IDX) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				// A new block joins the high-water mark here.
				sample.valid = is_alloc && wr_en_q;
				sample.value = new_end_q;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					mem_we  = wr_en_q;
					state_d = ST_IDLE;
					if (is_alloc) begin
						mem_wd.live       = 1'b1;
						mem_wd.slot_start = grant_q;
						mem_wd.slot_end   = new_end_q;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot counter: it sweeps the table during the clearing pass and gives the read address
	// during the walk. Read data come back in the next cycle together with their index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			issue_q <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			if (state_q == ST_CLEAR && cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + IW'(1);
			end else if (accept) begin
				cnt_q   <= FIRST_IDX;
				issue_q <= 1'b1;
			end else if (state_q == ST_SCAN && issue_q) begin
				v_s1 <= 1'b1;
				if (cnt_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem[cnt_q];
	end

	// Control of the walk. Empty slots between two live slots share one gap, so the walk
	// remembers the first empty slot of the current run and tests the gap when the run ends
	// at a live slot or at the end of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			any_empty_q <= 1'b0;
			done_q      <= 1'b0;
			wr_en_q     <= 1'b0;
			status_q    <= STAT_OK;
		end else if (accept) begin
			run_q       <= 1'b0;
			any_empty_q <= 1'b0;
			done_q      <= 1'b0;
			wr_en_q     <= 1'b0;
			status_q    <= STAT_OK;
		end else if (state_q == ST_SCAN && v_s1 && !done_q) begin
			if (is_alloc) begin
				if (rd_s1.live) begin
					run_q <= 1'b0;
					if (run_q && gap.fit) begin
						// The first fitting gap ends the search, even if the block would
						// run into the region end.
						done_q <= 1'b1;
						if (gap.reach) begin
							status_q <= STAT_MEM_FULL;
						end else begin
							wr_en_q <= 1'b1;
						end
					end
				end else begin
					any_empty_q <= 1'b1;
					run_q       <= 1'b1;
				end
			end else if (free_hit) begin
				done_q  <= 1'b1;
				wr_en_q <= 1'b1;
			end
		end else if (state_q == ST_FINAL && !done_q) begin
			done_q <= 1'b1;
			if (is_alloc) begin
				if (run_q && gap.fit) begin
					if (gap.reach) begin
						status_q <= STAT_MEM_FULL;
					end else begin
						wr_en_q <= 1'b1;
					end
				end else if (any_empty_q) begin
					status_q <= STAT_MEM_FULL;
				end else begin
					status_q <= STAT_TABLE_FULL;
				end
			end else begin
				status_q <= STAT_NOT_FOUND;
			end
		end
	end

	// Request fields and the values the walk collects.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			size_q   <= req.request_size;
			addr_q   <= req.block_address;
			pe_q     <= region_start_q;
			grant_q  <= '0;
		end else if (state_q == ST_SCAN && v_s1 && !done_q) begin
			if (is_alloc) begin
				if (rd_s1.live) begin
					pe_q <= rd_s1.slot_end;
					if (run_q && gap.fit && !gap.reach) begin
						grant_q   <= pe_q + ADDR_W'(1);
						new_end_q <= gap.new_end;
						sel_q     <= run_idx_q;
					end
				end else if (!run_q) begin
					run_idx_q <= idx_s1;
				end
			end else if (free_hit) begin
				sel_q      <= idx_s1;
				free_len_q <= rd_s1.slot_end - addr_q;
			end
		end else if (state_q == ST_FINAL && !done_q && is_alloc) begin
			if (run_q && gap.fit && !gap.reach) begin
				grant_q   <= pe_q + ADDR_W'(1);
				new_end_q <= gap.new_end;
				sel_q     <= run_idx_q;
			end
		end
	end

	assign upd.valid  = finish && wr_en_q;
	assign upd.add    = is_alloc;
	assign upd.amount = is_alloc ? size_q : free_len_q;

	ffra_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (accept),
		.sample       (sample),
		.upd          (upd),
		.region_start (region_start_q),
		.used_next    (used_next),
		.high_water   (high_water)
	);

	// Output register: the result waits here while the next request is being worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= status_q;
			out_grant_q  <= grant_q;
			out_used_q   <= used_next;
			out_hw_q     <= high_water;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.granted_address = out_grant_q;
	assign rsp.bytes_in_use    = out_used_q;
	assign rsp.high_water      = out_hw_q;

	// A result that is not a success never grants an address.
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_OK |-> rsp.granted_address == '0)
		else $error("failed request carries a granted address");

	// The table is never written while it is being walked.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !mem_we)
		else $error("slot table written during the walk");

	// One request at a time: ready drops right after a request is accepted.
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while another is in progress");

	// The sentinel slot is never read back during a walk.
	a_no_sentinel_read: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> idx_s1 != '0)
		else $error("walk returned the sentinel slot");

endmodule
